// ===== rtl/psf_pkg.sv =====
// ---------------------------------------------------------------------------
// psf_pkg
// Shared types, constants and the control store for the prime stream filter.
// ---------------------------------------------------------------------------
package psf_pkg;

  // Default configuration
  localparam int VALUE_BITS_DEF = 16;
  localparam int LIST_DEPTH_DEF = 128;

  // Fixed payload widths on the channels
  localparam int IN_VALUE_W = 16;
  localparam int OUT_VALUE_W = 16;
  localparam int SLOT_W = 8;
  localparam int COUNT_MAX = 255;

  // Control store addressing
  localparam int UPC_W = 4;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t U_WAIT    = 4'd0;
  localparam upc_t U_SMALL   = 4'd1;
  localparam upc_t U_SQUARE  = 4'd2;
  localparam upc_t U_CMP     = 4'd3;
  localparam upc_t U_DIV     = 4'd4;
  localparam upc_t U_TEST    = 4'd5;
  localparam upc_t U_NEXTD   = 4'd6;
  localparam upc_t U_EMIT    = 4'd7;
  localparam upc_t U_RESTART = 4'd8;
  localparam upc_t U_PRIME   = 4'd9;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_LOAD,
    OP_SQUARE,
    OP_DIV_STEP,
    OP_INC_D,
    OP_SET_PRIME,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    C_NEVER,
    C_ALWAYS,
    C_NOT_VALID,
    C_V_LT2,
    C_SQ_GT_V,
    C_DIV_BUSY,
    C_REM_ZERO,
    C_OUT_BUSY
  } cond_t;

  // One control word: datapath operation, jump condition, jump target.
  // A false condition falls through to the next step.
  typedef struct packed {
    op_t   op;
    cond_t cond;
    upc_t  target;
  } ctrl_t;

  function automatic ctrl_t ucode(input upc_t addr);
    ctrl_t w;
    w = '{op: OP_NONE, cond: C_ALWAYS, target: U_WAIT};
    unique case (addr)
      U_WAIT:    w = '{op: OP_LOAD,      cond: C_NOT_VALID, target: U_WAIT};
      U_SMALL:   w = '{op: OP_NONE,      cond: C_V_LT2,     target: U_EMIT};
      U_SQUARE:  w = '{op: OP_SQUARE,    cond: C_NEVER,     target: U_WAIT};
      U_CMP:     w = '{op: OP_NONE,      cond: C_SQ_GT_V,   target: U_PRIME};
      U_DIV:     w = '{op: OP_DIV_STEP,  cond: C_DIV_BUSY,  target: U_DIV};
      U_TEST:    w = '{op: OP_NONE,      cond: C_REM_ZERO,  target: U_EMIT};
      U_NEXTD:   w = '{op: OP_INC_D,     cond: C_ALWAYS,    target: U_SQUARE};
      U_EMIT:    w = '{op: OP_EMIT,      cond: C_OUT_BUSY,  target: U_EMIT};
      U_RESTART: w = '{op: OP_NONE,      cond: C_ALWAYS,    target: U_WAIT};
      U_PRIME:   w = '{op: OP_SET_PRIME, cond: C_ALWAYS,    target: U_EMIT};
      default:   w = '{op: OP_NONE,      cond: C_ALWAYS,    target: U_WAIT};
    endcase
    return w;
  endfunction

endpackage

// ===== rtl/psf_in_if.sv =====
// ---------------------------------------------------------------------------
// psf_in_if
// Input channel: one list element per beat.
// ---------------------------------------------------------------------------
interface psf_in_if;
  logic                             valid;
  logic                             ready;
  logic [psf_pkg::IN_VALUE_W-1:0]   value;
  logic                             is_last;

  modport source (output valid, output value, output is_last, input ready);
  modport sink   (input valid, input value, input is_last, output ready);
endinterface

// ===== rtl/psf_out_if.sv =====
// ---------------------------------------------------------------------------
// psf_out_if
// Result channel: one reported prime or end-of-list summary per beat.
// ---------------------------------------------------------------------------
interface psf_out_if;
  logic                             valid;
  logic                             ready;
  logic [psf_pkg::OUT_VALUE_W-1:0]  prime_value;
  logic [psf_pkg::SLOT_W-1:0]       slot_index;
  logic                             is_prime;
  logic                             end_of_list;

  modport source (output valid, output prime_value, output slot_index,
                  output is_prime, output end_of_list, input ready);
  modport sink   (input valid, input prime_value, input slot_index,
                  input is_prime, input end_of_list, output ready);
endinterface

// ===== rtl/prime_stream_filter_core.sv =====
// ---------------------------------------------------------------------------
// prime_stream_filter_core
// Trial-division primality filter over a stream of list elements.
// ---------------------------------------------------------------------------
// One element is taken at a time. It is tested by trial division with
// divisors d = 2, 3, ... while d*d <= value (this gives the same verdict as
// trying every divisor up to value/2). Each divisor is tried by a restoring
// divider that retires one quotient bit per cycle. Testing stops at the
// smallest divisor found; values below 2 skip the test and are not prime.
// A test may also wait on a result still held for the receiver. A prime
// that fits in the copied list is reported with its slot; the end-of-list
// element always gives one beat with the final count, after which the count
// clears. A finished result waits in the output register while the next
// element is already taken in.
module prime_stream_filter_core #(
  parameter int VALUE_BITS = psf_pkg::VALUE_BITS_DEF,
  parameter int LIST_DEPTH = psf_pkg::LIST_DEPTH_DEF
) (
  input  logic         clk,
  input  logic         rst_n,
  psf_in_if.sink       in_ch,
  psf_out_if.source    out_ch
);

  localparam int W     = VALUE_BITS;
  localparam int CNT_W = (W > 2) ? $clog2(W) : 1;
  localparam int CAP   = (LIST_DEPTH > psf_pkg::COUNT_MAX) ? psf_pkg::COUNT_MAX : LIST_DEPTH;
  localparam int IW    = psf_pkg::IN_VALUE_W;
  localparam int OW    = psf_pkg::OUT_VALUE_W;
  localparam int SW    = psf_pkg::SLOT_W;

  psf_pkg::upc_t  upc_r, upc_nxt;
  psf_pkg::ctrl_t ctrl;

  logic [W-1:0]     v_r;
  logic             last_r;
  logic [W-1:0]     d_r;
  logic [2*W-1:0]   sq_r;
  logic [W-1:0]     rem_r;
  logic [W-1:0]     quo_r;
  logic [CNT_W-1:0] cnt_r;
  logic             prime_r;
  logic [SW-1:0]    count_r;

  logic             out_valid_r;
  logic [OW-1:0]    out_value_r;
  logic [SW-1:0]    out_slot_r;
  logic             out_prime_r;
  logic             out_end_r;

  logic [IW+W-1:0]  in_ext;
  logic [W+OW-1:0]  v_ext;
  logic [2*W-1:0]   sq_full;
  logic [W:0]       rem_sh;
  logic [W:0]       rem_diff;
  logic             rem_ge;
  logic             div_done;
  logic             out_busy;
  logic             cond_hit;
  logic             copy;
  logic             emit_fire;
  logic             emit_beat;
  logic [SW-1:0]    count_inc;

  assign ctrl = psf_pkg::ucode(upc_r);

  assign in_ext   = {{W{1'b0}}, in_ch.value};
  assign v_ext    = {{OW{1'b0}}, v_r};
  assign sq_full  = d_r * d_r;
  assign rem_sh   = {rem_r, quo_r[W-1]};
  assign rem_diff = rem_sh - {1'b0, d_r};
  assign rem_ge   = rem_sh >= {1'b0, d_r};
  assign div_done = cnt_r == CNT_W'(W - 1);
  assign out_busy = out_valid_r && !out_ch.ready;

  assign copy      = prime_r && (count_r < SW'(CAP));
  assign count_inc = count_r + SW'(1);
  assign emit_fire = (ctrl.op == psf_pkg::OP_EMIT) && !out_busy;
  assign emit_beat = emit_fire && (last_r || copy);

  always_comb begin
    case (ctrl.cond)
      psf_pkg::C_NEVER:     cond_hit = 1'b0;
      psf_pkg::C_ALWAYS:    cond_hit = 1'b1;
      psf_pkg::C_NOT_VALID: cond_hit = !in_ch.valid;
      psf_pkg::C_V_LT2:     cond_hit = v_r < W'(2);
      psf_pkg::C_SQ_GT_V:   cond_hit = sq_r > {{W{1'b0}}, v_r};
      psf_pkg::C_DIV_BUSY:  cond_hit = !div_done;
      psf_pkg::C_REM_ZERO:  cond_hit = rem_r == '0;
      psf_pkg::C_OUT_BUSY:  cond_hit = out_busy;
      default:              cond_hit = 1'b0;
    endcase
    upc_nxt = cond_hit ? ctrl.target : upc_r + psf_pkg::upc_t'(1);
  end

  assign in_ch.ready        = ctrl.op == psf_pkg::OP_LOAD;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.prime_value = out_value_r;
  assign out_ch.slot_index  = out_slot_r;
  assign out_ch.is_prime    = out_prime_r;
  assign out_ch.end_of_list = out_end_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upc_r       <= psf_pkg::U_WAIT;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      upc_r <= upc_nxt;
      // drop the held beat once taken
      if (out_valid_r && out_ch.ready && !emit_beat) begin
        out_valid_r <= 1'b0;
      end
      unique case (ctrl.op)
        psf_pkg::OP_LOAD: begin
          v_r     <= in_ext[W-1:0];
          last_r  <= in_ch.is_last;
          d_r     <= W'(2);
          prime_r <= 1'b0;
        end
        psf_pkg::OP_SQUARE: begin
          sq_r  <= sq_full;
          rem_r <= '0;
          quo_r <= v_r;
          cnt_r <= '0;
        end
        psf_pkg::OP_DIV_STEP: begin
          rem_r <= rem_ge ? rem_diff[W-1:0] : rem_sh[W-1:0];
          quo_r <= {quo_r[W-2:0], 1'b0};
          cnt_r <= cnt_r + CNT_W'(1);
        end
        psf_pkg::OP_INC_D: begin
          d_r <= d_r + W'(1);
        end
        psf_pkg::OP_SET_PRIME: begin
          prime_r <= 1'b1;
        end
        psf_pkg::OP_EMIT: begin
          if (!out_busy) begin
            if (last_r) begin
              out_valid_r <= 1'b1;
              out_value_r <= copy ? v_ext[OW-1:0] : '0;
              out_slot_r  <= copy ? count_inc : count_r;
              out_prime_r <= copy;
              out_end_r   <= 1'b1;
              count_r     <= '0;
            end else if (copy) begin
              out_valid_r <= 1'b1;
              out_value_r <= v_ext[OW-1:0];
              out_slot_r  <= count_r;
              out_prime_r <= 1'b1;
              out_end_r   <= 1'b0;
              count_r     <= count_inc;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // An accepted beat always starts the small-value check next.
  a_accept_seq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (upc_r == psf_pkg::U_SMALL))
    else $error("accepted beat did not start a test");

  // The copied count never passes the list capacity.
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= SW'(CAP))
    else $error("copied count beyond capacity");

  // The end-of-list beat clears the count.
  a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (emit_fire && last_r) |=> (count_r == '0 && out_valid_r && out_end_r))
    else $error("end of list did not clear the count");

  // A test never ends with an emit while the input is being taken.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    emit_fire |-> !in_ch.ready)
    else $error("emit overlapped with load");

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// Self-checking bench for prime_stream_filter_core. Lists of elements go in
// through a driver fed from a queue; each accepted beat is screened by a
// trial-division predictor that tracks the copied-prime count. A monitor
// matches every result beat against the oldest expected verdict.
// Stimulus covers edge values, lists that end on a prime and on a non-prime,
// a list that overruns the copy limit, random lists, random idling on both
// channels and one long result stall.
// ---------------------------------------------------------------------------
module testbench;

  localparam int LIST_CAP      = (psf_pkg::LIST_DEPTH_DEF > psf_pkg::COUNT_MAX) ?
                                 psf_pkg::COUNT_MAX : psf_pkg::LIST_DEPTH_DEF;
  localparam int RANDOM_ITEMS  = 100;
  localparam int FULL_LIST_LEN = LIST_CAP + 4;
  localparam int HOLD_CYCLES   = 600;
  localparam int TAIL_CYCLES   = 6000;
  localparam int IDLE_LIMIT    = 30000;
  localparam int LARGEST_PRIME = 65521;

  typedef struct {
    logic [psf_pkg::IN_VALUE_W-1:0] value;
    logic                           is_last;
  } element_t;

  typedef struct {
    logic [psf_pkg::OUT_VALUE_W-1:0] prime_value;
    logic [psf_pkg::SLOT_W-1:0]      slot_index;
    logic                            is_prime;
    logic                            end_of_list;
  } verdict_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  psf_in_if  in_ch();
  psf_out_if out_ch();

  prime_stream_filter_core #(
    .VALUE_BITS(psf_pkg::VALUE_BITS_DEF),
    .LIST_DEPTH(psf_pkg::LIST_DEPTH_DEF)
  ) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  element_t                   pending_elems[$];
  verdict_t                   expected_verdicts[$];
  logic [psf_pkg::SLOT_W-1:0] primes_copied;

  int mismatch_count = 0;
  int in_beats = 0;
  int out_beats = 0;
  int primes_seen = 0;
  int lists_closed = 0;
  int burst_start = -1;
  int idle_cycles = 0;
  int src_wait = 0;
  int sink_wait = 0;
  int hold_left = 0;
  bit hold_done = 1'b0;
  bit src_quiet = 1'b0;
  bit sink_quiet = 1'b0;

  always #4 clk = ~clk;

  function automatic bit has_no_divisor(input int unsigned v);
    int unsigned d;
    if (v < 2) return 1'b0;
    for (d = 2; d <= v / 2; d++) begin
      if (v % d == 0) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic int unsigned prime_at_or_above(input int unsigned v);
    int unsigned p;
    p = (v > LARGEST_PRIME) ? LARGEST_PRIME : v;
    while (!has_no_divisor(p)) p++;
    return p;
  endfunction

  function automatic int unsigned draw_value();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 35) return $urandom_range(0, 200);
    if (pick < 55) return $urandom_range(0, 4095);
    if (pick < 75) return $urandom & 32'hFFFF;
    return prime_at_or_above($urandom & 32'hFFFF);
  endfunction

  function automatic void add_elem(input int unsigned v, input bit last);
    element_t e;
    e.value = v[psf_pkg::IN_VALUE_W-1:0];
    e.is_last = last;
    pending_elems.push_back(e);
  endfunction

  // Screen one accepted element: update the copied count, queue any verdict.
  function void screen_element(input logic [psf_pkg::IN_VALUE_W-1:0] v, input logic last);
    verdict_t                   r;
    bit                         copied;
    logic [psf_pkg::SLOT_W-1:0] slot;
    copied = 1'b0;
    slot = '0;
    if (has_no_divisor(v) && primes_copied < LIST_CAP) begin
      slot = primes_copied;
      primes_copied = primes_copied + 1'b1;
      copied = 1'b1;
    end
    if (last) begin
      r.prime_value = copied ? v : '0;
      r.slot_index = primes_copied;
      r.is_prime = copied;
      r.end_of_list = 1'b1;
      expected_verdicts.push_back(r);
      primes_copied = '0;
    end else if (copied) begin
      r.prime_value = v;
      r.slot_index = slot;
      r.is_prime = 1'b1;
      r.end_of_list = 1'b0;
      expected_verdicts.push_back(r);
    end
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t: %s", $time, what);
    mismatch_count++;
  endtask

  // Input driver
  always @(posedge clk) begin : drive_elements
    element_t e;
    int       g;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      in_ch.value <= '0;
      in_ch.is_last <= 1'b0;
      primes_copied = '0;
      src_wait <= 0;
    end else if (!(in_ch.valid && !in_ch.ready)) begin
      if (in_ch.valid) begin
        screen_element(in_ch.value, in_ch.is_last);
        in_beats <= in_beats + 1;
        if ($urandom_range(0, 15) == 0) src_quiet = !src_quiet;
        g = src_quiet ? 0 : $urandom_range(0, 11);
      end else begin
        g = src_wait;
      end
      if (g == 0 && pending_elems.size() > 0) begin
        e = pending_elems.pop_front();
        in_ch.valid <= 1'b1;
        in_ch.value <= e.value;
        in_ch.is_last <= e.is_last;
      end else begin
        in_ch.valid <= 1'b0;
        src_wait <= (g > 0) ? g - 1 : 0;
      end
    end
  end

  // Result monitor and receiver
  always @(posedge clk) begin : check_results
    verdict_t x;
    int       w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      sink_wait <= 0;
      hold_left <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        out_beats <= out_beats + 1;
        if (out_ch.is_prime) primes_seen++;
        if (out_ch.end_of_list) lists_closed++;
        if (expected_verdicts.size() == 0) begin
          report_mismatch($sformatf("unexpected beat value=%0d slot=%0d prime=%0b end=%0b",
                                    out_ch.prime_value, out_ch.slot_index,
                                    out_ch.is_prime, out_ch.end_of_list));
        end else begin
          x = expected_verdicts.pop_front();
          if (out_ch.prime_value !== x.prime_value)
            report_mismatch($sformatf("prime_value got %0d want %0d",
                                      out_ch.prime_value, x.prime_value));
          if (out_ch.slot_index !== x.slot_index)
            report_mismatch($sformatf("slot_index got %0d want %0d",
                                      out_ch.slot_index, x.slot_index));
          if (out_ch.is_prime !== x.is_prime)
            report_mismatch($sformatf("is_prime got %0b want %0b",
                                      out_ch.is_prime, x.is_prime));
          if (out_ch.end_of_list !== x.end_of_list)
            report_mismatch($sformatf("end_of_list got %0b want %0b",
                                      out_ch.end_of_list, x.end_of_list));
        end
      end
      // Hold off once the overrun list starts, so the block backs up
      if (!hold_done && burst_start >= 0 && in_beats > burst_start) begin
        hold_done = 1'b1;
        hold_left <= HOLD_CYCLES;
        out_ch.ready <= 1'b0;
      end else if (hold_left > 0) begin
        hold_left <= hold_left - 1;
        out_ch.ready <= 1'b0;
      end else if (out_ch.valid && out_ch.ready) begin
        if ($urandom_range(0, 15) == 0) sink_quiet = !sink_quiet;
        w = sink_quiet ? 0 : $urandom_range(0, 11);
        sink_wait <= w;
        out_ch.ready <= (w == 0);
      end else if (sink_wait > 0) begin
        sink_wait <= sink_wait - 1;
        out_ch.ready <= (sink_wait == 1);
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : watchdog
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : stimulus
    int n;
    int len;
    int k;

    // Edge values, squares and powers of two; list ends on a copied prime
    add_elem(0, 0);
    add_elem(1, 0);
    add_elem(2, 0);
    add_elem(3, 0);
    add_elem(4, 0);
    add_elem(65535, 0);
    add_elem(LARGEST_PRIME, 0);
    add_elem(49, 0);
    add_elem(65025, 0);
    add_elem(32768, 0);
    add_elem(7, 1);
    // List of a single non-prime
    add_elem(65534, 1);
    // List ending on a non-prime after one prime
    add_elem(5, 0);
    add_elem(1, 1);
    // Single-element lists: smallest prime, zero, largest prime
    add_elem(2, 1);
    add_elem(0, 1);
    add_elem(LARGEST_PRIME, 1);
    // Mixed tail
    add_elem(4093, 0);
    add_elem(4097, 0);
    add_elem(121, 0);
    add_elem(65533, 1);

    n = 0;
    while (n < RANDOM_ITEMS) begin
      if (burst_start < 0 && n >= 30) begin
        // Overrun the copy limit with quick small primes; the tail is dropped
        burst_start = pending_elems.size();
        for (k = 0; k < FULL_LIST_LEN; k++)
          add_elem(prime_at_or_above($urandom_range(0, 13)), k == FULL_LIST_LEN - 1);
      end
      len = $urandom_range(1, 10);
      for (k = 0; k < len; k++)
        add_elem(draw_value(), k == len - 1);
      n += len;
    end

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    @(posedge clk);
    while (pending_elems.size() > 0 || in_ch.valid || expected_verdicts.size() > 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Screened %0d elements over %0d lists; %0d result beats, %0d primes reported.",
             in_beats, lists_closed, out_beats, primes_seen);
    $display("Included a list past the %0d-entry copy limit and a %0d-cycle result stall.",
             LIST_CAP, HOLD_CYCLES);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/psf_pkg.sv
rtl/psf_in_if.sv
rtl/psf_out_if.sv
rtl/prime_stream_filter_core.sv
dv/testbench.sv
